@@ design/pnnt_pkg.sv @@
// ----------------------------------------------------------------------------
// Projected nearest-neighbor table package
// Shared widths, codes and payload types for the table, its cells and the
// projection unit.
// ----------------------------------------------------------------------------
package pnnt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DIMENSIONS_DEF  = 3;

  localparam int POS_BITS   = 24;
  localparam int VALUE_BITS = 32;
  localparam int DIR_BITS   = 16;
  localparam int KEY_BITS   = 40;
  localparam int OP_BITS    = 2;
  localparam int ST_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;

  // Cells whose bracket selections are merged in one registered group.
  localparam int GRP_SIZE = 16;

  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

  localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z = 2'd2;

  localparam logic signed [DIR_BITS-1:0] DIR_X_RESET = 16'sd16384;
  localparam logic signed [DIR_BITS-1:0] DIR_Y_RESET = 16'sd0;
  localparam logic signed [DIR_BITS-1:0] DIR_Z_RESET = 16'sd0;

  localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
  localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};

  typedef struct packed {
    logic [OP_BITS-1:0]           operation;
    logic signed [POS_BITS-1:0]   pos_x;
    logic signed [POS_BITS-1:0]   pos_y;
    logic signed [POS_BITS-1:0]   pos_z;
    logic signed [VALUE_BITS-1:0] sample_value;
  } pnnt_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] result_value;
    logic [ST_BITS-1:0]           status;
  } pnnt_out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                         insert;
    logic                         bracket;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } pnnt_ctrl_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic                         le;
    logic                         shift;
    logic                         ge_stop;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } pnnt_link_t;

  // Bracket entries, zero unless the cell is selected.
  typedef struct packed {
    logic signed [KEY_BITS-1:0]   lo_key;
    logic signed [KEY_BITS-1:0]   hi_key;
    logic signed [VALUE_BITS-1:0] lo_val;
    logic signed [VALUE_BITS-1:0] hi_val;
  } pnnt_sel_t;

endpackage

@@ design/pnnt_project.sv @@
// ----------------------------------------------------------------------------
// Projection unit
// Two-stage dot product of a point with the direction vector, saturated to
// the key width.
// ----------------------------------------------------------------------------
module pnnt_project #(
  parameter int DIMENSIONS = pnnt_pkg::DIMENSIONS_DEF
) (
  input  logic                                   clk,
  input  pnnt_pkg::pnnt_in_t                     item,
  input  logic signed [pnnt_pkg::DIR_BITS-1:0]   dir_x,
  input  logic signed [pnnt_pkg::DIR_BITS-1:0]   dir_y,
  input  logic signed [pnnt_pkg::DIR_BITS-1:0]   dir_z,
  output logic signed [pnnt_pkg::KEY_BITS-1:0]   key
);

  localparam int PROD_W      = pnnt_pkg::POS_BITS + pnnt_pkg::DIR_BITS;
  localparam int SUM_W       = PROD_W + 2;
  localparam int KEY_BITS_LO = pnnt_pkg::KEY_BITS - 1;

  logic signed [pnnt_pkg::POS_BITS-1:0] pos_a [3];
  logic signed [pnnt_pkg::DIR_BITS-1:0] dir_a [3];
  logic signed [PROD_W-1:0]             prod_nxt [3];
  logic signed [PROD_W-1:0]             prod_r [3];
  logic signed [SUM_W-1:0]              sum;
  logic [SUM_W-KEY_BITS_LO-1:0]         upper;
  logic signed [pnnt_pkg::KEY_BITS-1:0] key_nxt;
  logic signed [pnnt_pkg::KEY_BITS-1:0] key_r;

  assign pos_a[0] = item.pos_x;
  assign pos_a[1] = item.pos_y;
  assign pos_a[2] = item.pos_z;
  assign dir_a[0] = dir_x;
  assign dir_a[1] = dir_y;
  assign dir_a[2] = dir_z;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      if (d < DIMENSIONS) begin
        prod_nxt[d] = PROD_W'(pos_a[d]) * PROD_W'(dir_a[d]);
      end else begin
        prod_nxt[d] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      prod_r[d] <= prod_nxt[d];
    end
    key_r <= key_nxt;
  end

  // The sum fits the key when all bits from the key's sign upward agree.
  always_comb begin
    sum   = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    upper = sum[SUM_W-1:KEY_BITS_LO];
    if ((&upper) || (~|upper)) begin
      key_nxt = sum[pnnt_pkg::KEY_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      key_nxt = pnnt_pkg::KEY_MIN;
    end else begin
      key_nxt = pnnt_pkg::KEY_MAX;
    end
  end

  assign key = key_r;

endmodule

@@ design/pnnt_cell.sv @@
// ----------------------------------------------------------------------------
// Table cell
// Holds one sorted (key, value) entry, shifts right on insert and marks
// itself as the low or high end of a query bracket.
// ----------------------------------------------------------------------------
module pnnt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pnnt_pkg::pnnt_ctrl_t ctrl,
  input  logic [CNT_W-1:0]     count,
  input  pnnt_pkg::pnnt_link_t prev,
  input  logic                 next_is_c,
  output pnnt_pkg::pnnt_link_t link,
  output logic                 is_c,
  output pnnt_pkg::pnnt_sel_t  sel,
  output logic                 hi_sel
);

  logic signed [pnnt_pkg::KEY_BITS-1:0]   key_r;
  logic signed [pnnt_pkg::VALUE_BITS-1:0] val_r;
  logic                                   sel_lo_r;
  logic                                   sel_hi_r;
  logic                                   valid;
  logic                                   last;
  logic                                   le;
  logic                                   ge;

  assign valid = CNT_W'(IDX) < count;
  assign last  = count == CNT_W'(IDX + 1);
  assign le    = valid && (key_r <= ctrl.key);
  assign ge    = key_r >= ctrl.key;

  assign link.le      = le;
  assign link.shift   = valid && !le;
  assign link.ge_stop = (IDX >= 1) && valid && ge;
  assign link.key     = key_r;
  assign link.value   = val_r;

  // This cell is the upper bracket entry when it is the first entry from
  // index one on whose key reaches the query key, or the last entry.
  assign is_c = (IDX >= 1) && valid && (ge || last) && !prev.ge_stop;

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (prev.shift) begin
        key_r <= prev.key;
        val_r <= prev.value;
      end else if (!le && prev.le) begin
        key_r <= ctrl.key;
        val_r <= ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_lo_r <= 1'b0;
      sel_hi_r <= 1'b0;
    end else if (ctrl.bracket) begin
      sel_lo_r <= next_is_c;
      sel_hi_r <= is_c;
    end
  end

  assign sel.lo_key = sel_lo_r ? key_r : '0;
  assign sel.hi_key = sel_hi_r ? key_r : '0;
  assign sel.lo_val = sel_lo_r ? val_r : '0;
  assign sel.hi_val = sel_hi_r ? val_r : '0;
  assign hi_sel     = sel_hi_r;

endmodule

@@ design/projected_nearest_neighbor_table_unit.sv @@
// ----------------------------------------------------------------------------
// Projected nearest-neighbor table
// Projects points onto a direction vector and keeps a sorted table of
// (key, value) entries in a row of cells; queries return the value of the
// entry whose key lies nearest.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    pnnt_in_t  (operation, pos, value)
//  out_     output     out_valid / out_stall  pnnt_out_t (result_value, status)
//  cfg_     input      cfg_we                 cfg_index, cfg_wdata (direction)
//
//  One item at a time. Query and add pass through the two-stage projection
//  multiplier; an add then shifts the cell row, and a query runs the
//  registered gather of the bracket entries from the cells.
//  Clear, unused codes, full add, empty or single-entry query go straight to the result.
//  Reset empties the table and loads the direction (1, 0, 0); no sweep.
//  A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module projected_nearest_neighbor_table_unit #(
  parameter int TABLE_DEPTH = pnnt_pkg::TABLE_DEPTH_DEF,
  parameter int DIMENSIONS  = pnnt_pkg::DIMENSIONS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  pnnt_pkg::pnnt_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output pnnt_pkg::pnnt_out_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [pnnt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [pnnt_pkg::DIR_BITS-1:0]          cfg_wdata
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int GROUPS = (TABLE_DEPTH + pnnt_pkg::GRP_SIZE - 1) / pnnt_pkg::GRP_SIZE;
  localparam int PAD_N  = GROUPS * pnnt_pkg::GRP_SIZE;
  localparam int DIFF_W = pnnt_pkg::KEY_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_INS  = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_GRP  = 8'b0010_0000,
    S_DIST = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                                 state_r, state_nxt;
  logic [CNT_W-1:0]                       cnt_r, cnt_nxt;
  pnnt_pkg::pnnt_in_t                     item_r, item_nxt;
  logic signed [pnnt_pkg::VALUE_BITS-1:0] res_r, res_nxt;
  logic [pnnt_pkg::ST_BITS-1:0]           st_r, st_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  pnnt_pkg::pnnt_out_t                    out_data_r, out_data_nxt;
  logic signed [pnnt_pkg::DIR_BITS-1:0]   dir_x_r, dir_y_r, dir_z_r;

  logic                                   in_acc;
  logic                                   full;
  logic signed [pnnt_pkg::KEY_BITS-1:0]   key;
  pnnt_pkg::pnnt_ctrl_t                   ctrl;
  pnnt_pkg::pnnt_link_t                   links [TABLE_DEPTH];
  logic                                   is_c [TABLE_DEPTH];
  pnnt_pkg::pnnt_sel_t                    sel_a [PAD_N];
  logic [TABLE_DEPTH-1:0]                 hi_vec;
  pnnt_pkg::pnnt_sel_t                    grp_nxt [GROUPS];
  pnnt_pkg::pnnt_sel_t                    grp_r [GROUPS];
  pnnt_pkg::pnnt_sel_t                    pick;
  logic signed [DIFF_W-1:0]               d_lo, d_hi;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Direction registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r <= pnnt_pkg::DIR_X_RESET;
      dir_y_r <= pnnt_pkg::DIR_Y_RESET;
      dir_z_r <= pnnt_pkg::DIR_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pnnt_pkg::REG_DIR_X: dir_x_r <= cfg_wdata;
        pnnt_pkg::REG_DIR_Y: dir_y_r <= cfg_wdata;
        pnnt_pkg::REG_DIR_Z: dir_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pnnt_project #(
    .DIMENSIONS(DIMENSIONS)
  ) u_project (
    .clk   (clk),
    .item  (item_r),
    .dir_x (dir_x_r),
    .dir_y (dir_y_r),
    .dir_z (dir_z_r),
    .key   (key)
  );

  assign ctrl.insert  = (state_r == S_INS);
  assign ctrl.bracket = (state_r == S_CMP);
  assign ctrl.key     = key;
  assign ctrl.value   = item_r.sample_value;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pnnt_pkg::pnnt_link_t prev_link;
    logic                 next_c;

    if (i == 0) begin : g_head
      assign prev_link = '{le: 1'b1, shift: 1'b0, ge_stop: 1'b0, key: '0, value: '0};
    end else begin : g_body
      assign prev_link = links[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_c = 1'b0;
    end else begin : g_mid
      assign next_c = is_c[i+1];
    end

    pnnt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .count     (cnt_r),
      .prev      (prev_link),
      .next_is_c (next_c),
      .link      (links[i]),
      .is_c      (is_c[i]),
      .sel       (sel_a[i]),
      .hi_sel    (hi_vec[i])
    );
  end

  for (genvar p = TABLE_DEPTH; p < PAD_N; p++) begin : g_pad
    assign sel_a[p] = '0;
  end

  // Registered first level of the bracket gather.
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < pnnt_pkg::GRP_SIZE; k++) begin
        grp_nxt[g] = pnnt_pkg::pnnt_sel_t'(grp_nxt[g] | sel_a[g*pnnt_pkg::GRP_SIZE + k]);
      end
    end

    always_ff @(posedge clk) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    pick = '0;
    for (int g = 0; g < GROUPS; g++) begin
      pick = pnnt_pkg::pnnt_sel_t'(pick | grp_r[g]);
    end
    d_lo = DIFF_W'(key) - DIFF_W'(pick.lo_key);
    d_hi = DIFF_W'(pick.hi_key) - DIFF_W'(key);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          st_nxt    = pnnt_pkg::ST_OK;
          state_nxt = S_DONE;
          case (in_data.operation)
            pnnt_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            pnnt_pkg::OP_ADD: begin
              if (full) begin
                st_nxt = pnnt_pkg::ST_FULL;
              end else begin
                state_nxt = S_MUL;
              end
            end
            pnnt_pkg::OP_QUERY: begin
              if (cnt_r == '0) begin
                st_nxt = pnnt_pkg::ST_EMPTY;
              end else if (cnt_r == CNT_W'(1)) begin
                res_nxt = links[0].value;
              end else begin
                state_nxt = S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = (item_r.operation == pnnt_pkg::OP_ADD) ? S_INS : S_CMP;
      end
      S_INS: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_CMP: begin
        state_nxt = S_GRP;
      end
      S_GRP: begin
        state_nxt = S_DIST;
      end
      S_DIST: begin
        // A tie goes to the upper entry.
        res_nxt   = (d_lo < d_hi) ? pick.lo_val : pick.hi_val;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_value = res_r;
          out_data_nxt.status       = st_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  // An insert never runs into a full row of cells.
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> !full)
    else $error("insert started on a full table");

  // The entry count never passes the depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // After the bracket step exactly one cell holds the upper bracket entry.
  a_one_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRP) |-> $onehot(hi_vec))
    else $error("bracket selection is not one-hot");

  // A new result appears only when the controller hands one over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the hand-over state");

  // The block accepts no item while one is still in work.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

endmodule
